/* src/cdr_pkg.sv */
package cdr_pkg;

  localparam int MAX_RATINGS = 16;
  localparam int VALUE_BITS  = 32;

  localparam int IDX_W      = $clog2(MAX_RATINGS);
  localparam int CNT_W      = 5;
  localparam int PERIOD_W   = 14;
  localparam int ENTRY_W    = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam int FRAC_BITS = VALUE_BITS - 1;
  localparam int PROD_W    = 2 * VALUE_BITS;
  localparam int RND_W     = VALUE_BITS + 2;
  localparam int ACC_W     = VALUE_BITS + IDX_W + 1;

  localparam logic [VALUE_BITS-1:0] ONE_VAL  = VALUE_BITS'(1) << FRAC_BITS;
  localparam logic [PROD_W:0]       HALF_LSB = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

  localparam logic [CNT_W-1:0]    RST_RATING_COUNT = CNT_W'(16);
  localparam logic [IDX_W-1:0]    RST_DEFAULT_IDX  = IDX_W'(15);
  localparam logic [PERIOD_W-1:0] RST_PERIOD_LIMIT = PERIOD_W'(12);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_STEP    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATING_COUNT  = 2'd0,
    CFG_DEFAULT_INDEX = 2'd1,
    CFG_PERIOD_LIMIT  = 2'd2
  } cfg_reg_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT,
    ST_ERR
  } state_t;

endpackage

/* src/cumulative_default_rate.sv */
// Cumulative default rate generator. Load the N x N rating transition matrix
// with mode 0 transfers (one Q1.31 entry each, values above 1.0 clip to 1.0),
// then each mode 1 transfer returns N results: for every starting rating i the
// probability of having reached the default rating d by period t, i.e. entry i
// of M^t e_d, with last set on rating N-1. Period 0 returns the unit vector and
// each later request advances the stored column by one matrix-vector product.
// A request at or beyond period_limit returns a single result with status 1
// and leaves the state alone. Mode 2 and any write to a defined configuration
// register restart at period 0. The block takes one transfer at a time: in_stall
// stays high until every result of the current request has been taken. A
// request for period t >= 1 runs all N*N products through a single shared
// 32x32 multiply-accumulate fed from the matrix RAM: for each row it issues the
// N products, drains the pipeline and emits the row's result, and out_stall
// can hold each result; period 0 and the error result skip the
// multiply-accumulate.
module cumulative_default_rate (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [cdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cdr_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cdr_pkg::MODE_W-1:0]    in_mode,
  input  logic [cdr_pkg::IDX_W-1:0]     in_row_index,
  input  logic [cdr_pkg::IDX_W-1:0]     in_col_index,
  input  logic [cdr_pkg::ENTRY_W-1:0]   in_entry_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cdr_pkg::IDX_W-1:0]     out_rating,
  output logic [cdr_pkg::PERIOD_W-1:0]  out_period,
  output logic [cdr_pkg::VALUE_BITS-1:0] out_probability,
  output logic                          out_status,
  output logic                          out_last
);
  import cdr_pkg::*;

  // configuration registers
  logic [CNT_W-1:0]    count_r;
  logic [IDX_W-1:0]    defidx_r;
  logic [PERIOD_W-1:0] limit_r;

  // sequencer
  state_t              state_r, state_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic [IDX_W-1:0]    row_r;
  logic [IDX_W-1:0]    k_r;

  // current column v_(t-1) and the one being built
  logic [VALUE_BITS-1:0] col_r     [MAX_RATINGS];
  logic [VALUE_BITS-1:0] nxt_col_r [MAX_RATINGS];

  // matrix RAM, written by loads, read once per MAC issue
  logic [VALUE_BITS-1:0] tstore_r [MAX_RATINGS][MAX_RATINGS];

  // MAC pipeline: issue -> read/operand -> product -> accumulate
  logic [VALUE_BITS-1:0] mem_q_r;
  logic [VALUE_BITS-1:0] colv_r;
  logic                  v1_r, last1_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  v2_r, last2_r;
  logic [ACC_W-1:0]      acc_r;

  // result register
  logic                  out_valid_r;
  logic [IDX_W-1:0]      out_rating_r;
  logic [PERIOD_W-1:0]   out_period_r;
  logic [VALUE_BITS-1:0] out_prob_r;
  logic                  out_status_r;
  logic                  out_last_r;

  logic                  in_xfer, out_xfer;
  mode_t                 mode;
  logic [CNT_W-1:0]      used_n;
  logic [IDX_W-1:0]      n_m1;
  logic                  over_limit;
  logic [IDX_W-1:0]      row_inc;
  logic [RND_W-1:0]      rnd;
  logic [ACC_W-1:0]      row_sum;
  logic [VALUE_BITS-1:0] row_val;
  logic                  mac_done;
  logic [VALUE_BITS-1:0] load_val;
  logic                  load_ok;
  logic                  cfg_hit;
  logic [IDX_W-1:0]      defidx_new;

  // control strobes
  logic                  do_store, do_restart, start_mac, start_row, next_row;
  logic                  commit, nxt_wr, out_load;
  logic [IDX_W-1:0]      ld_rating;
  logic [VALUE_BITS-1:0] ld_prob;
  logic                  ld_status, ld_last;

  assign in_stall        = (state_r != ST_IDLE);
  assign in_xfer         = in_valid & ~in_stall;
  assign out_xfer        = out_valid_r & ~out_stall;
  assign mode            = mode_t'(in_mode);

  assign out_valid       = out_valid_r;
  assign out_rating      = out_rating_r;
  assign out_period      = out_period_r;
  assign out_probability = out_prob_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

  // matrix order: 0 acts as 1, anything above the store acts as full size
  always_comb begin
    if (count_r == '0) begin
      used_n = CNT_W'(1);
    end else if (count_r > CNT_W'(MAX_RATINGS)) begin
      used_n = CNT_W'(MAX_RATINGS);
    end else begin
      used_n = count_r;
    end
  end
  assign n_m1       = IDX_W'(used_n - CNT_W'(1));
  assign over_limit = (period_r >= limit_r);
  assign row_inc    = row_r + IDX_W'(1);

  // product rounded to nearest (ties up), then row sum clipped at 1.0
  assign rnd      = RND_W'(({1'b0, prod_r} + HALF_LSB) >> FRAC_BITS);
  assign row_sum  = acc_r + ACC_W'(rnd);
  assign row_val  = (row_sum > ACC_W'(ONE_VAL)) ? ONE_VAL : VALUE_BITS'(row_sum);
  assign mac_done = v2_r & last2_r;

  assign load_val = (VALUE_BITS'(in_entry_value) > ONE_VAL) ? ONE_VAL
                                                            : VALUE_BITS'(in_entry_value);
  assign load_ok  = (int'(in_row_index) < MAX_RATINGS) && (int'(in_col_index) < MAX_RATINGS);

  assign cfg_hit    = cfg_we && ((cfg_index == CFG_RATING_COUNT) ||
                                 (cfg_index == CFG_DEFAULT_INDEX) ||
                                 (cfg_index == CFG_PERIOD_LIMIT));
  assign defidx_new = (cfg_we && (cfg_index == CFG_DEFAULT_INDEX)) ? cfg_data[IDX_W-1:0]
                                                                   : defidx_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (mode == MODE_STEP)) begin
          if (over_limit) begin
            state_nxt = ST_ERR;
          end else if (period_r == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        if (k_r == n_m1) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (mac_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer) begin
          if (row_r == n_m1) begin
            state_nxt = ST_IDLE;
          end else if (period_r == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_MAC;
          end
        end
      end
      ST_ERR: begin
        if (out_xfer) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    do_store   = 1'b0;
    do_restart = cfg_hit;
    start_mac  = 1'b0;
    start_row  = 1'b0;
    next_row   = 1'b0;
    commit     = 1'b0;
    nxt_wr     = 1'b0;
    out_load   = 1'b0;
    ld_rating  = '0;
    ld_prob    = '0;
    ld_status  = STATUS_OK;
    ld_last    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (mode)
            MODE_LOAD:    do_store = load_ok;
            MODE_RESTART: do_restart = 1'b1;
            MODE_STEP: begin
              if (over_limit) begin
                out_load  = 1'b1;
                ld_status = STATUS_LIMIT;
                ld_last   = 1'b1;
              end else if (period_r == '0) begin
                out_load = 1'b1;
                ld_prob  = (defidx_r == '0) ? ONE_VAL : '0;
                ld_last  = (n_m1 == '0);
              end else begin
                start_mac = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          out_load  = 1'b1;
          nxt_wr    = 1'b1;
          ld_rating = row_r;
          ld_prob   = row_val;
          ld_last   = (row_r == n_m1);
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          if (row_r == n_m1) begin
            commit = 1'b1;
          end else begin
            next_row = 1'b1;
            if (period_r == '0) begin
              // period 0 is the unit vector at the default rating
              out_load  = 1'b1;
              ld_rating = row_inc;
              ld_prob   = (row_inc == defidx_r) ? ONE_VAL : '0;
              ld_last   = (row_inc == n_m1);
            end else begin
              start_row = 1'b1;
            end
          end
        end
      end
      ST_MAC, ST_ERR: ;
      default: ;
    endcase
  end

  // matrix RAM
  always_ff @(posedge clk) begin
    if (do_store) tstore_r[in_row_index][in_col_index] <= load_val;
    mem_q_r <= tstore_r[row_r][k_r];
  end

  // MAC datapath registers
  always_ff @(posedge clk) begin
    colv_r <= col_r[k_r];
    prod_r <= PROD_W'(mem_q_r) * PROD_W'(colv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= RST_RATING_COUNT;
      defidx_r    <= RST_DEFAULT_IDX;
      limit_r     <= RST_PERIOD_LIMIT;
      period_r    <= '0;
      row_r       <= '0;
      k_r         <= '0;
      v1_r        <= 1'b0;
      last1_r     <= 1'b0;
      v2_r        <= 1'b0;
      last2_r     <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < MAX_RATINGS; j++) begin
        col_r[j] <= (j == int'(RST_DEFAULT_IDX)) ? ONE_VAL : '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RATING_COUNT:  count_r  <= cfg_data[CNT_W-1:0];
          CFG_DEFAULT_INDEX: defidx_r <= cfg_data[IDX_W-1:0];
          CFG_PERIOD_LIMIT:  limit_r  <= cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end

      // period counter and stored column
      if (do_restart) begin
        period_r <= '0;
        for (int j = 0; j < MAX_RATINGS; j++) begin
          col_r[j] <= (j == int'(defidx_new)) ? ONE_VAL : '0;
        end
      end else if (commit) begin
        period_r <= period_r + PERIOD_W'(1);
        if (period_r != '0) begin
          for (int j = 0; j < MAX_RATINGS; j++) begin
            col_r[j] <= (j <= int'(n_m1)) ? nxt_col_r[j] : '0;
          end
        end
      end

      // row index rests at 0 between requests so period 0 starts at rating 0
      if (start_mac || commit) begin
        row_r <= '0;
      end else if (next_row) begin
        row_r <= row_inc;
      end

      if (start_mac || start_row) begin
        k_r <= '0;
      end else if (state_r == ST_MAC) begin
        k_r <= k_r + IDX_W'(1);
      end

      v1_r    <= (state_r == ST_MAC);
      last1_r <= (k_r == n_m1);
      v2_r    <= v1_r;
      last2_r <= last1_r;

      // accumulator clears itself at the end of each row
      if (v2_r) begin
        acc_r <= last2_r ? '0 : row_sum;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload and next-column write
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rating_r <= ld_rating;
      out_period_r <= period_r;
      out_prob_r   <= ld_prob;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
    end
    if (nxt_wr) nxt_col_r[row_r] <= row_val;
  end

endmodule

/* src/cdr_checker.sv */
module cdr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [cdr_pkg::IDX_W-1:0]      out_rating,
  input logic [cdr_pkg::PERIOD_W-1:0]   out_period,
  input logic [cdr_pkg::VALUE_BITS-1:0] out_probability,
  input logic                           out_status,
  input logic                           out_last
);
  import cdr_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_probability) &&
                               $stable(out_rating) && $stable(out_period))
    else $error("result changed while stalled");

  // no new request is taken while results are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  // the limit result is a lone, empty result
  a_limit_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_LIMIT) |->
      out_last && (out_probability == '0) && (out_rating == '0))
    else $error("malformed limit result");

  // probabilities never exceed 1.0
  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_probability <= ONE_VAL)
    else $error("probability above one");

  // period 0 is a unit vector
  a_period0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_OK) && (out_period == '0) |->
      (out_probability == '0) || (out_probability == ONE_VAL))
    else $error("period 0 result not 0 or 1");

endmodule

bind cumulative_default_rate cdr_checker u_cdr_checker (.*);

/* tb/cumulative_default_rate_tb.sv */
`timescale 1ns / 1ps

module cumulative_default_rate_tb;
  import cdr_pkg::*;

  // Mode 3 and register index 3 are outside the defined sets; the block must
  // ignore both.
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  // Rounding constant for Q1.31 products: half an LSB of the result.
  localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_BITS - 1);

  typedef struct packed {
    logic [IDX_W-1:0]      rating;
    logic [PERIOD_W-1:0]   period;
    logic [VALUE_BITS-1:0] probability;
    logic                  status;
    logic                  last;
  } default_prob_t;

  // Tracks the matrix, the stored default column and the period counter,
  // and keeps the queue of default probabilities still owed by the block.
  class absorption_scoreboard;
    logic [VALUE_BITS-1:0] matrix [MAX_RATINGS][MAX_RATINGS];
    bit                    written [MAX_RATINGS][MAX_RATINGS];
    logic [VALUE_BITS-1:0] column [MAX_RATINGS];
    logic [PERIOD_W-1:0]   period;
    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      default_reg;
    logic [PERIOD_W-1:0]   limit_reg;
    default_prob_t         expected_q [$];
    int                    mismatches;

    function new();
      count_reg   = RST_RATING_COUNT;
      default_reg = RST_DEFAULT_IDX;
      limit_reg   = RST_PERIOD_LIMIT;
      mismatches  = 0;
      restart();
    endfunction

    function void restart();
      foreach (column[i]) column[i] = '0;
      column[default_reg] = ONE_VAL;
      period = '0;
    endfunction

    // Matrix order in use: 0 behaves as 1, anything above the store as full size.
    function int order();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_RATINGS) return MAX_RATINGS;
      return count_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_RATING_COUNT:  count_reg   = data[CNT_W-1:0];
        CFG_DEFAULT_INDEX: default_reg = data[IDX_W-1:0];
        CFG_PERIOD_LIMIT:  limit_reg   = data[PERIOD_W-1:0];
        default:           return;
      endcase
      restart();
    endfunction

    function void note_input(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic [ENTRY_W-1:0] value);
      int                    n;
      logic [63:0]           acc;
      logic [VALUE_BITS-1:0] advanced [MAX_RATINGS];
      default_prob_t         res;
      if (mode == MODE_LOAD) begin
        matrix[row][col]  = (value > ONE_VAL) ? ONE_VAL : value[VALUE_BITS-1:0];
        written[row][col] = 1'b1;
      end else if (mode == MODE_RESTART) begin
        restart();
      end else if (mode == MODE_STEP) begin
        if (period >= limit_reg) begin
          res = '{rating: '0, period: period, probability: '0,
                  status: STATUS_LIMIT, last: 1'b1};
          expected_q.push_back(res);
        end else begin
          n = order();
          if (period != 0) begin
            // v_t = M * v_(t-1), rounded products, saturating row sums
            foreach (advanced[i]) advanced[i] = '0;
            for (int i = 0; i < n; i++) begin
              acc = '0;
              for (int k = 0; k < n; k++)
                acc += (64'(matrix[i][k]) * 64'(column[k]) + ROUND_HALF) >> FRAC_BITS;
              advanced[i] = (acc > 64'(ONE_VAL)) ? ONE_VAL : acc[VALUE_BITS-1:0];
            end
            column = advanced;
          end
          for (int i = 0; i < n; i++) begin
            res = '{rating: IDX_W'(i), period: period, probability: column[i],
                    status: STATUS_OK, last: (i == n - 1)};
            expected_q.push_back(res);
          end
          period = period + 1'b1;
        end
      end
    endfunction

    function void check_result(default_prob_t got);
      default_prob_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: rating %0d period %0d prob %h status %b last %b",
                   got.rating, got.period, got.probability, got.status, got.last);
        return;
      end
      exp = expected_q.pop_front();
      if (got.rating !== exp.rating || got.period !== exp.period ||
          got.probability !== exp.probability || got.status !== exp.status ||
          got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected rating %0d period %0d prob %h status %b last %b",
                   exp.rating, exp.period, exp.probability, exp.status, exp.last);
          $display("                 actual   rating %0d period %0d prob %h status %b last %b",
                   got.rating, got.period, got.probability, got.status, got.last);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [MODE_W-1:0]     in_mode;
  logic [IDX_W-1:0]      in_row_index;
  logic [IDX_W-1:0]      in_col_index;
  logic [ENTRY_W-1:0]    in_entry_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [IDX_W-1:0]      out_rating;
  logic [PERIOD_W-1:0]   out_period;
  logic [VALUE_BITS-1:0] out_probability;
  logic                  out_status;
  logic                  out_last;

  absorption_scoreboard sb = new();

  // While set, neither side inserts bubbles or back-pressure.
  bit steady = 1'b0;
  int sent_items = 0;

  cumulative_default_rate i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_entry_value  (in_entry_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rating      (out_rating),
    .out_period      (out_period),
    .out_probability (out_probability),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: sample at the edge (pre-edge values), then pick the next
  // stall, asserted with a 7% chance at each pick unless steady is set.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result('{rating: out_rating, period: out_period,
                          probability: out_probability, status: out_status,
                          last: out_last});
      out_stall <= !steady && ($urandom_range(99) < 7);
    end
  end

  // One input transfer. Called at a clock edge; returns at the edge where the
  // transfer happened, with valid still high, so the caller either presents
  // the next item or drops valid in the same step.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [ENTRY_W-1:0] value);
    if (!steady && $urandom_range(99) < 7) begin
      // mostly short bubbles, sometimes long enough to land mid-emission
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(4, 80) : $urandom_range(1, 3))
        @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_row_index   <= row;
    in_col_index   <= col;
    in_entry_value <= value;
    do @(posedge clk); while (in_stall);
    sb.note_input(mode, row, col, value);
    if (mode != MODE_UNUSED) sent_items++;
  endtask

  // Matrix entry: mostly row-sized probabilities, plus zero, exactly one,
  // values above one and raw random words.
  function automatic logic [ENTRY_W-1:0] draw_entry(int n);
    int r;
    r = $urandom_range(99);
    if (r < 6)  return '0;
    if (r < 10) return ONE_VAL;
    if (r < 14) return 32'h8000_0000 | $urandom;
    if (r < 22) return $urandom;
    return $urandom_range(0, ONE_VAL / n);
  endfunction

  // Step request. A period past zero reads every entry of the active matrix,
  // so any entry not loaded yet is loaded first.
  task automatic request_period();
    int n;
    n = sb.order();
    if (sb.period != 0 && sb.period < sb.limit_reg)
      for (int i = 0; i < n; i++)
        for (int k = 0; k < n; k++)
          if (!sb.written[i][k])
            send_item(MODE_LOAD, IDX_W'(i), IDX_W'(k), draw_entry(n));
    send_item(MODE_STEP, IDX_W'($urandom), IDX_W'($urandom), $urandom);
  endtask

  task automatic random_item();
    int n;
    int r;
    n = sb.order();
    r = $urandom_range(99);
    if (r < 48)
      request_period();
    else if (r < 85)
      send_item(MODE_LOAD,
                ($urandom_range(99) < 80) ? IDX_W'($urandom_range(0, n - 1))
                                          : IDX_W'($urandom),
                ($urandom_range(99) < 80) ? IDX_W'($urandom_range(0, n - 1))
                                          : IDX_W'($urandom),
                draw_entry(n));
    else if (r < 93)
      send_item(MODE_RESTART, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    else
      send_item(MODE_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
  endtask

  // Drop valid and wait until every owed result is back, then let a trailing
  // load or restart retire.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Back-to-back register writes; optionally also pokes the unused index,
  // which must neither change a setting nor restart the sequence.
  task automatic configure(input logic [CFG_DATA_W-1:0] count_v,
                           input logic [CFG_DATA_W-1:0] dflt_v,
                           input logic [CFG_DATA_W-1:0] limit_v,
                           input bit touch_unused);
    logic [CFG_IDX_W-1:0]  regs [4];
    logic [CFG_DATA_W-1:0] vals [4];
    regs = '{CFG_RATING_COUNT, CFG_DEFAULT_INDEX, CFG_PERIOD_LIMIT, CFG_UNUSED};
    vals = '{count_v, dflt_v, limit_v, CFG_DATA_W'($urandom)};
    for (int i = 0; i < (touch_unused ? 4 : 3); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_RATING_COUNT;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_mode        <= MODE_LOAD;
    in_row_index   <= '0;
    in_col_index   <= '0;
    in_entry_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings (16 ratings, default 15): period 0 needs no matrix and
    // must give the unit vector. Mode 3 is ignored; a restart rewinds.
    request_period();
    send_item(MODE_UNUSED, '1, '1, '1);
    send_item(MODE_RESTART, '0, '0, '0);
    request_period();

    // Two ratings: over-range loads clip to 1.0, a corner entry outside the
    // active matrix, a load between periods, then two limit errors.
    settle();
    configure(14'd2, 14'd1, 14'd3, 1'b0);
    send_item(MODE_LOAD, 4'd0, 4'd0, 32'hFFFF_FFFF);
    send_item(MODE_LOAD, 4'd0, 4'd1, 32'h0000_0000);
    send_item(MODE_LOAD, 4'd1, 4'd0, 32'h8000_0001);
    send_item(MODE_LOAD, 4'd1, 4'd1, 32'h4000_0000);
    send_item(MODE_LOAD, 4'd15, 4'd15, 32'h7FFF_FFFF);
    request_period();
    request_period();
    send_item(MODE_LOAD, 4'd1, 4'd1, ONE_VAL);
    request_period();
    request_period();
    request_period();

    // Count 0 acts as one rating; default index outside the active set gives
    // an all-zero column. The unused register index is written too.
    settle();
    configure(14'd0, 14'd5, 14'd2, 1'b1);
    request_period();
    request_period();
    request_period();

    // Limit of zero: even period 0 is refused.
    settle();
    configure(14'd0, 14'd5, 14'd0, 1'b0);
    request_period();

    // Count above the store acts as 16; limit 1 allows period 0 only.
    settle();
    configure(14'd20, 14'd0, 14'd1, 1'b0);
    request_period();
    request_period();

    // Random phases, small orders. Phase 0 has the largest period limit,
    // phase 1 the smallest legal order and limit, phase 2 runs with no
    // bubbles or stalls on either side.
    for (int phase = 0; sent_items < 170; phase++) begin
      settle();
      steady = (phase == 2);
      case (phase)
        0:       configure(14'd8, 14'd0, 14'd16383, 1'b0);
        1:       configure(14'd1, 14'd0, 14'd2, 1'b1);
        default: configure({9'($urandom), 5'($urandom_range(1, 8))},
                           {10'($urandom), 4'($urandom_range(0, 15))},
                           14'($urandom_range(2, 14)), $urandom_range(1));
      endcase
      repeat (40) random_item();
    end

    // Full-size matrix last: the first deep period fills whatever entries
    // are still unloaded, then the column is stepped up to the limit.
    settle();
    steady = 1'b0;
    configure({9'($urandom), 5'd16}, {10'($urandom), 4'($urandom_range(0, 15))},
              14'd10, 1'b0);
    repeat (30) random_item();

    settle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
